// ===== rtl/gftq_pkg.sv =====
// Shared sizes, codes, entry types and address helper for the team queue.
package gftq_pkg;

	localparam int TEAMS      = 16;
	localparam int TEAM_DEPTH = 64;

	localparam int KIND_W   = 1;
	localparam int TEAM_IN_W = 5;
	localparam int MEMBER_W = 20;
	localparam int STATUS_W = 2;

	localparam int TEAM_W  = $clog2(TEAMS);
	localparam int SLOT_W  = $clog2(TEAM_DEPTH);
	localparam int CNT_W   = $clog2(TEAM_DEPTH + 1);
	localparam int OCNT_W  = $clog2(TEAMS + 1);
	localparam int MEM_DEPTH = TEAMS * TEAM_DEPTH;
	localparam int MEM_AW  = $clog2(MEM_DEPTH);

	typedef enum logic [KIND_W-1:0] {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [SLOT_W-1:0] head;
		logic [CNT_W-1:0]  count;
	} team_ent_t;

	localparam int TEAM_ENT_W = SLOT_W + CNT_W;

	function automatic logic [MEM_AW-1:0] mem_addr(input logic [TEAM_W-1:0] t,
			input logic [SLOT_W-1:0] slot);
		mem_addr = MEM_AW'(t) * MEM_AW'(TEAM_DEPTH) + MEM_AW'(slot);
	endfunction

endpackage

// ===== rtl/gftq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module gftq_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/gftq_team_tbl.sv =====
// Per-team head pointer and count table: RAM plus valid bits that read as zero after reset.
module gftq_team_tbl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [gftq_pkg::TEAM_W-1:0]   rd_idx,
	input  logic                          wr_en,
	input  logic [gftq_pkg::TEAM_W-1:0]   wr_idx,
	input  gftq_pkg::team_ent_t           wr_ent,
	output gftq_pkg::team_ent_t           rd_ent
);

	logic [gftq_pkg::TEAMS-1:0]          valid_q;
	logic [gftq_pkg::TEAM_W-1:0]         rd_idx_q;
	logic [gftq_pkg::TEAM_ENT_W-1:0]     raw_data;

	gftq_ram #(
		.DATA_W(gftq_pkg::TEAM_ENT_W),
		.DEPTH (gftq_pkg::TEAMS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_idx),
		.wr_data(wr_ent),
		.rd_en  (rd_en),
		.rd_addr(rd_idx),
		.rd_data(raw_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_q <= rd_idx;
		end
	end

	// never-written entries read as an empty team
	assign rd_ent = valid_q[rd_idx_q] ? gftq_pkg::team_ent_t'(raw_data) : '0;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !rd_en)
		else $error("team table read and write in the same cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_ent.count <= gftq_pkg::CNT_W'(gftq_pkg::TEAM_DEPTH))
		else $error("team count written beyond depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_ent.head <= gftq_pkg::SLOT_W'(gftq_pkg::TEAM_DEPTH - 1))
		else $error("team head written beyond depth");

endmodule

// ===== rtl/grouped_fifo_team_queue.sv =====
// Team queue top level: sequencer, team order ring and member store.
//
// Input channel (in_valid / in_stall) carries one item: kind selects enqueue or
// dequeue; team (one-based) and member_id matter only on enqueue. Every item
// produces exactly one result on the output channel (out_valid / out_stall):
// out_member holds the removed member on a successful dequeue and zero
// otherwise; status is ok, dequeue while empty, or enqueue into full team
// (an out-of-range team number counts as full).
// One item is worked at a time. For an enqueue or a rejected item the team
// table is read at the accepting edge and updated, together with the result
// register, once that register is free. A successful dequeue chains the team
// table read and then the member store read through synchronous RAMs before
// its result is registered. in_stall goes low at the edge that registers the
// result, so a new item is taken only once the last one's result is registered.
// A result waits in the output register while out_stall is high; the next item
// is still accepted and worked up to the point where its result would need
// that register, where it holds.
// Reset clears the team table valid bits and the order pointers at once;
// there is no clearing pass and the block accepts items right after reset.
module grouped_fifo_team_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [gftq_pkg::KIND_W-1:0]        kind,
	input  logic [gftq_pkg::TEAM_IN_W-1:0]     team,
	input  logic [gftq_pkg::MEMBER_W-1:0]      member_id,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [gftq_pkg::MEMBER_W-1:0]      out_member,
	output logic [gftq_pkg::STATUS_W-1:0]      status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_TEAM,
		S_MEM
	} state_t;

	localparam int SUM_W  = gftq_pkg::CNT_W + 1;
	localparam int OSUM_W = gftq_pkg::OCNT_W + 1;

	state_t                              state_q;
	gftq_pkg::kind_t                     kind_q;
	logic                                team_bad_q;
	logic                                empty_q;
	logic [gftq_pkg::TEAM_W-1:0]         tidx_q;
	logic [gftq_pkg::MEMBER_W-1:0]       member_q;

	logic [gftq_pkg::TEAM_W-1:0]         order_ring_q [gftq_pkg::TEAMS];
	logic [gftq_pkg::TEAM_W-1:0]         order_head_q;
	logic [gftq_pkg::OCNT_W-1:0]         order_count_q;

	logic                                out_valid_q;
	logic [gftq_pkg::MEMBER_W-1:0]       out_member_q;
	gftq_pkg::status_t                   status_q;

	logic                                accept;
	logic                                out_free;
	logic                                res_load;
	logic [gftq_pkg::TEAM_IN_W-1:0]      team_m1;
	logic                                team_bad;
	logic [gftq_pkg::TEAM_W-1:0]         rd_tidx;

	gftq_pkg::team_ent_t                 ent;
	gftq_pkg::team_ent_t                 team_wr_ent;
	logic                                team_wr_en;
	logic                                enq_ok;
	logic                                deq_ok;
	logic                                fire;
	logic [SUM_W-1:0]                    slot_sum;
	logic [gftq_pkg::SLOT_W-1:0]         slot;
	logic [gftq_pkg::SLOT_W-1:0]         head_nx;
	logic [OSUM_W-1:0]                   pos_sum;
	logic [gftq_pkg::TEAM_W-1:0]         order_pos;
	logic [gftq_pkg::TEAM_W-1:0]         order_head_nx;

	logic                                mem_wr_en;
	logic                                mem_rd_en;
	logic [gftq_pkg::MEM_AW-1:0]         mem_wr_addr;
	logic [gftq_pkg::MEM_AW-1:0]         mem_rd_addr;
	logic [gftq_pkg::MEMBER_W-1:0]       mem_rd_data;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign team_m1  = team - gftq_pkg::TEAM_IN_W'(1);
	assign team_bad = (team == '0) || (32'(team) > 32'(gftq_pkg::TEAMS));

	always_comb begin
		if (gftq_pkg::kind_t'(kind) == gftq_pkg::KIND_ENQ) begin
			rd_tidx = gftq_pkg::TEAM_W'(team_m1);
		end else if (order_count_q == '0) begin
			rd_tidx = '0;
		end else begin
			rd_tidx = order_ring_q[order_head_q];
		end
	end

	gftq_team_tbl u_team_tbl (
		.clk   (clk),
		.arst_n(arst_n),
		.rd_en (accept),
		.rd_idx(rd_tidx),
		.wr_en (team_wr_en),
		.wr_idx(tidx_q),
		.wr_ent(team_wr_ent),
		.rd_ent(ent)
	);

	gftq_ram #(
		.DATA_W(gftq_pkg::MEMBER_W),
		.DEPTH (gftq_pkg::MEM_DEPTH)
	) u_member_ram (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(member_q),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// team slot and pointer arithmetic
	assign slot_sum = SUM_W'(ent.head) + SUM_W'(ent.count);
	assign slot     = (slot_sum >= SUM_W'(gftq_pkg::TEAM_DEPTH)) ?
		gftq_pkg::SLOT_W'(slot_sum - SUM_W'(gftq_pkg::TEAM_DEPTH)) :
		gftq_pkg::SLOT_W'(slot_sum);
	assign head_nx  = (ent.head == gftq_pkg::SLOT_W'(gftq_pkg::TEAM_DEPTH - 1)) ?
		'0 : ent.head + gftq_pkg::SLOT_W'(1);

	assign pos_sum   = OSUM_W'(order_head_q) + OSUM_W'(order_count_q);
	assign order_pos = (pos_sum >= OSUM_W'(gftq_pkg::TEAMS)) ?
		gftq_pkg::TEAM_W'(pos_sum - OSUM_W'(gftq_pkg::TEAMS)) :
		gftq_pkg::TEAM_W'(pos_sum);
	assign order_head_nx = (order_head_q == gftq_pkg::TEAM_W'(gftq_pkg::TEAMS - 1)) ?
		'0 : order_head_q + gftq_pkg::TEAM_W'(1);

	assign enq_ok = !team_bad_q && (ent.count != gftq_pkg::CNT_W'(gftq_pkg::TEAM_DEPTH));
	assign deq_ok = !empty_q && (ent.count != '0);

	// a good dequeue moves on to the member read without needing the output slot
	assign fire = (state_q == S_TEAM) &&
		(out_free || (kind_q == gftq_pkg::KIND_DEQ && deq_ok));

	assign mem_wr_en   = fire && kind_q == gftq_pkg::KIND_ENQ && enq_ok;
	assign mem_rd_en   = fire && kind_q == gftq_pkg::KIND_DEQ && deq_ok;
	assign mem_wr_addr = gftq_pkg::mem_addr(tidx_q, slot);
	assign mem_rd_addr = gftq_pkg::mem_addr(tidx_q, ent.head);

	assign res_load = (fire && !mem_rd_en) || (state_q == S_MEM && out_free);

	always_comb begin
		team_wr_en  = 1'b0;
		team_wr_ent = ent;
		if (mem_wr_en) begin
			team_wr_en        = 1'b1;
			team_wr_ent.count = ent.count + gftq_pkg::CNT_W'(1);
		end else if (mem_rd_en) begin
			team_wr_en        = 1'b1;
			team_wr_ent.head  = head_nx;
			team_wr_ent.count = ent.count - gftq_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			member_q <= member_id;
			tidx_q   <= rd_tidx;
		end
		if (mem_wr_en && ent.count == '0 &&
				order_count_q < gftq_pkg::OCNT_W'(gftq_pkg::TEAMS)) begin
			order_ring_q[order_pos] <= tidx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			kind_q        <= gftq_pkg::KIND_ENQ;
			team_bad_q    <= 1'b0;
			empty_q       <= 1'b0;
			order_head_q  <= '0;
			order_count_q <= '0;
			out_valid_q   <= 1'b0;
			out_member_q  <= '0;
			status_q      <= gftq_pkg::ST_OK;
		end else begin
			// load a new result, or drop the one just taken
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q     <= gftq_pkg::kind_t'(kind);
						team_bad_q <= team_bad;
						empty_q    <= (order_count_q == '0);
						state_q    <= S_TEAM;
					end
				end
				S_TEAM: begin
					if (fire) begin
						if (mem_rd_en) begin
							// drop the team from the order when it empties
							if (ent.count == gftq_pkg::CNT_W'(1)) begin
								order_head_q  <= order_head_nx;
								order_count_q <= order_count_q - gftq_pkg::OCNT_W'(1);
							end
							state_q <= S_MEM;
						end else begin
							if (mem_wr_en && ent.count == '0 &&
									order_count_q < gftq_pkg::OCNT_W'(gftq_pkg::TEAMS)) begin
								order_count_q <= order_count_q + gftq_pkg::OCNT_W'(1);
							end
							out_member_q <= '0;
							if (kind_q == gftq_pkg::KIND_DEQ) begin
								status_q <= gftq_pkg::ST_EMPTY;
							end else if (enq_ok) begin
								status_q <= gftq_pkg::ST_OK;
							end else begin
								status_q <= gftq_pkg::ST_FULL;
							end
							state_q <= S_IDLE;
						end
					end
				end
				S_MEM: begin
					if (out_free) begin
						out_member_q <= mem_rd_data;
						status_q     <= gftq_pkg::ST_OK;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_member = out_member_q;
	assign status     = status_q;

	a_order_bound: assert property (@(posedge clk) disable iff (!arst_n)
		order_count_q <= gftq_pkg::OCNT_W'(gftq_pkg::TEAMS))
		else $error("team order count beyond team total");

	a_mem_wr_enq: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (state_q == S_TEAM && kind_q == gftq_pkg::KIND_ENQ && !team_bad_q))
		else $error("member store written outside an enqueue");

	a_mem_state_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MEM) |-> (kind_q == gftq_pkg::KIND_DEQ && !empty_q))
		else $error("member read stage entered without a live dequeue");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_member_q)))
		else $error("stalled result lost or changed");

endmodule
